// ===== sv/ps2mrp_pkg.sv =====
// Shared types, state codes and step tables for the PS/2 mouse poll sequencer.
`default_nettype none

package ps2mrp_pkg;

  // Parameter defaults
  localparam int POS_WIDTH_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLL_IDX   = 2'd0;
  localparam logic [1:0] CFG_RATE_IDX   = 2'd1;
  localparam logic [1:0] CFG_RES_IDX    = 2'd2;
  localparam logic [1:0] CFG_SETTLE_IDX = 2'd3;

  // Configuration reset values
  localparam logic [31:0] POLL_RST   = 32'd1000;
  localparam logic [7:0]  RATE_RST   = 8'd200;
  localparam logic [1:0]  RES_RST    = 2'd3;
  localparam logic [15:0] SETTLE_RST = 16'd100;

  // Mouse command bytes
  localparam logic [7:0] CMD_RESET      = 8'hFF;
  localparam logic [7:0] CMD_REMOTE     = 8'hF0;
  localparam logic [7:0] CMD_SAMPLE     = 8'hF3;
  localparam logic [7:0] CMD_RESOLUTION = 8'hE8;
  localparam logic [7:0] CMD_READ_DATA  = 8'hEB;

  // Status byte bits
  localparam int STAT_X_SIGN = 4;
  localparam int STAT_Y_SIGN = 5;
  localparam int STAT_X_OVF  = 6;
  localparam int STAT_Y_OVF  = 7;

  // Step kinds
  localparam logic [3:0] K_IDLE     = 4'd0;
  localparam logic [3:0] K_START    = 4'd1;
  localparam logic [3:0] K_SETTLE   = 4'd2;
  localparam logic [3:0] K_WR       = 4'd3;
  localparam logic [3:0] K_RD       = 4'd4;
  localparam logic [3:0] K_BUSY     = 4'd5;
  localparam logic [3:0] K_UPDATE   = 4'd6;
  localparam logic [3:0] K_POLLWAIT = 4'd7;
  localparam logic [3:0] K_WR_SR    = 4'd8;
  localparam logic [3:0] K_WR_RES   = 4'd9;

  // Sequencer state codes (WR = send, RD = read request, WB = wait link idle)
  localparam logic [5:0] ST_IDLE          = 6'd0;
  localparam logic [5:0] ST_START         = 6'd1;
  localparam logic [5:0] ST_SETTLE_INIT   = 6'd2;
  localparam logic [5:0] ST_RST_WR        = 6'd3;
  localparam logic [5:0] ST_RST_WB        = 6'd4;
  localparam logic [5:0] ST_RSTACK_RD     = 6'd5;
  localparam logic [5:0] ST_RSTACK_WB     = 6'd6;
  localparam logic [5:0] ST_BLANK1_RD     = 6'd7;
  localparam logic [5:0] ST_BLANK1_WB     = 6'd8;
  localparam logic [5:0] ST_BLANK2_RD     = 6'd9;
  localparam logic [5:0] ST_BLANK2_WB     = 6'd10;
  localparam logic [5:0] ST_REM_WR        = 6'd11;
  localparam logic [5:0] ST_REM_WB        = 6'd12;
  localparam logic [5:0] ST_REMACK_RD     = 6'd13;
  localparam logic [5:0] ST_REMACK_WB     = 6'd14;
  localparam logic [5:0] ST_SR_WR         = 6'd15;
  localparam logic [5:0] ST_SR_WB         = 6'd16;
  localparam logic [5:0] ST_SRACK_RD      = 6'd17;
  localparam logic [5:0] ST_SRACK_WB      = 6'd18;
  localparam logic [5:0] ST_SRARG_WR      = 6'd19;
  localparam logic [5:0] ST_SRARG_WB      = 6'd20;
  localparam logic [5:0] ST_SRARGACK_RD   = 6'd21;
  localparam logic [5:0] ST_SRARGACK_WB   = 6'd22;
  localparam logic [5:0] ST_RES_WR        = 6'd23;
  localparam logic [5:0] ST_RES_WB        = 6'd24;
  localparam logic [5:0] ST_RESACK_RD     = 6'd25;
  localparam logic [5:0] ST_RESACK_WB     = 6'd26;
  localparam logic [5:0] ST_RESARG_WR     = 6'd27;
  localparam logic [5:0] ST_RESARG_WB     = 6'd28;
  localparam logic [5:0] ST_RESARGACK_RD  = 6'd29;
  localparam logic [5:0] ST_SETUP_END_WB  = 6'd30;
  localparam logic [5:0] ST_SETTLE_SETUP  = 6'd31;
  localparam logic [5:0] ST_POLL_WR       = 6'd32;
  localparam logic [5:0] ST_POLL_WB       = 6'd33;
  localparam logic [5:0] ST_POLLACK_RD    = 6'd34;
  localparam logic [5:0] ST_POLLACK_WB    = 6'd35;
  localparam logic [5:0] ST_STAT_RD       = 6'd36;
  localparam logic [5:0] ST_STAT_WB       = 6'd37;
  localparam logic [5:0] ST_X_RD          = 6'd38;
  localparam logic [5:0] ST_X_WB          = 6'd39;
  localparam logic [5:0] ST_Y_RD          = 6'd40;
  localparam logic [5:0] ST_Y_WB          = 6'd41;
  localparam logic [5:0] ST_UPDATE        = 6'd42;
  localparam logic [5:0] ST_POLLWAIT      = 6'd43;

  // Configuration values seen by the sequencer
  typedef struct packed {
    logic [31:0] poll_us;
    logic [7:0]  sample_rate;
    logic [1:0]  resolution;
    logic [15:0] settle_us;
  } cfg_t;

  // Per-request control fields handed to the sequencer
  typedef struct packed {
    logic       start_req;
    logic       link_busy;
    logic [7:0] rx_byte;
  } step_ctl_t;

  // Link command and status of one result
  typedef struct packed {
    logic       write_request;
    logic [7:0] write_data;
    logic       read_request;
    logic       overflow_flag;
    logic [7:0] status_byte;
  } seq_res_t;

  // Kind of work done in each state
  function automatic logic [3:0] step_kind(input logic [5:0] st);
    logic [3:0] k;
    unique case (st) inside
      ST_START: k = K_START;
      ST_SETTLE_INIT, ST_SETTLE_SETUP: k = K_SETTLE;
      ST_RST_WR, ST_REM_WR, ST_SR_WR, ST_RES_WR, ST_POLL_WR: k = K_WR;
      ST_SRARG_WR: k = K_WR_SR;
      ST_RESARG_WR: k = K_WR_RES;
      ST_RSTACK_RD, ST_BLANK1_RD, ST_BLANK2_RD, ST_REMACK_RD, ST_SRACK_RD,
      ST_SRARGACK_RD, ST_RESACK_RD, ST_RESARGACK_RD, ST_POLLACK_RD,
      ST_STAT_RD, ST_X_RD, ST_Y_RD: k = K_RD;
      ST_RST_WB, ST_RSTACK_WB, ST_BLANK1_WB, ST_BLANK2_WB, ST_REM_WB,
      ST_REMACK_WB, ST_SR_WB, ST_SRACK_WB, ST_SRARG_WB, ST_SRARGACK_WB,
      ST_RES_WB, ST_RESACK_WB, ST_RESARG_WB, ST_SETUP_END_WB, ST_POLL_WB,
      ST_POLLACK_WB, ST_STAT_WB, ST_X_WB, ST_Y_WB: k = K_BUSY;
      ST_UPDATE: k = K_UPDATE;
      ST_POLLWAIT: k = K_POLLWAIT;
      default: k = K_IDLE;
    endcase
    return k;
  endfunction

  // Fixed command byte of each command send state; argument sends take their byte from the settings
  function automatic logic [7:0] step_byte(input logic [5:0] st);
    logic [7:0] b;
    unique case (st)
      ST_RST_WR:  b = CMD_RESET;
      ST_REM_WR:  b = CMD_REMOTE;
      ST_SR_WR:   b = CMD_SAMPLE;
      ST_RES_WR:  b = CMD_RESOLUTION;
      ST_POLL_WR: b = CMD_READ_DATA;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ps2mrp_seq.sv =====
// Sequencer state, timers, packet capture and position accumulators.
`default_nettype none

module ps2mrp_seq #(
  parameter int POS_WIDTH  = ps2mrp_pkg::POS_WIDTH_DEF,
  parameter int TIME_WIDTH = ps2mrp_pkg::TIME_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          advance,
  input  ps2mrp_pkg::step_ctl_t        ctl,
  input  wire  [TIME_WIDTH-1:0]        now_us,
  input  ps2mrp_pkg::cfg_t             cfg,
  output ps2mrp_pkg::seq_res_t         res,
  output logic signed [POS_WIDTH-1:0]  pos_x,
  output logic signed [POS_WIDTH-1:0]  pos_y
);

  logic [5:0]            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] mark_r, mark_nxt;
  logic [7:0]            status_r, status_nxt;
  logic [7:0]            xbyte_r, xbyte_nxt;
  logic [7:0]            ybyte_r, ybyte_nxt;
  logic [POS_WIDTH-1:0]  xacc_r, xacc_nxt;
  logic [POS_WIDTH-1:0]  yacc_r, yacc_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  wreq_r, wreq_nxt;
  logic                  rreq_r, rreq_nxt;
  logic [7:0]            wdata_r, wdata_nxt;

  logic [5:0]            st;
  logic [3:0]            kind;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  settle_done;
  logic                  poll_done;
  logic [POS_WIDTH-1:0]  dx;
  logic [POS_WIDTH-1:0]  dy;

  // Start request overrides the current state
  assign st   = ctl.start_req ? ps2mrp_pkg::ST_START : state_r;
  assign kind = ps2mrp_pkg::step_kind(st);

  // Wrapping elapsed time since the last mark
  assign elapsed     = now_us - mark_r;
  assign settle_done = elapsed >= TIME_WIDTH'(cfg.settle_us);
  assign poll_done   = 32'(elapsed) >= cfg.poll_us;

  // Sign-extend the 9-bit deltas
  assign dx = {{(POS_WIDTH-8){status_r[ps2mrp_pkg::STAT_X_SIGN]}}, xbyte_r};
  assign dy = {{(POS_WIDTH-8){status_r[ps2mrp_pkg::STAT_Y_SIGN]}}, ybyte_r};

  // Step the sequencer for one request
  always_comb begin
    state_nxt  = st;
    mark_nxt   = mark_r;
    status_nxt = status_r;
    xbyte_nxt  = xbyte_r;
    ybyte_nxt  = ybyte_r;
    xacc_nxt   = xacc_r;
    yacc_nxt   = yacc_r;
    ovf_nxt    = ovf_r;
    wreq_nxt   = 1'b0;
    rreq_nxt   = 1'b0;
    wdata_nxt  = 8'h00;
    unique case (kind)
      ps2mrp_pkg::K_START: begin
        mark_nxt  = now_us;
        state_nxt = st + 6'd1;
      end
      ps2mrp_pkg::K_SETTLE: begin
        if (settle_done) begin
          state_nxt = st + 6'd1;
        end
      end
      ps2mrp_pkg::K_WR: begin
        wreq_nxt  = 1'b1;
        wdata_nxt = ps2mrp_pkg::step_byte(st);
        state_nxt = st + 6'd1;
      end
      ps2mrp_pkg::K_WR_SR: begin
        wreq_nxt  = 1'b1;
        wdata_nxt = cfg.sample_rate;
        state_nxt = st + 6'd1;
      end
      ps2mrp_pkg::K_WR_RES: begin
        wreq_nxt  = 1'b1;
        wdata_nxt = {6'd0, cfg.resolution};
        state_nxt = st + 6'd1;
      end
      ps2mrp_pkg::K_RD: begin
        rreq_nxt  = 1'b1;
        state_nxt = st + 6'd1;
      end
      ps2mrp_pkg::K_BUSY: begin
        if (!ctl.link_busy) begin
          if (st == ps2mrp_pkg::ST_SETUP_END_WB) begin
            mark_nxt = now_us;
          end else if (st == ps2mrp_pkg::ST_STAT_WB) begin
            status_nxt = ctl.rx_byte;
          end else if (st == ps2mrp_pkg::ST_X_WB) begin
            xbyte_nxt = ctl.rx_byte;
          end else if (st == ps2mrp_pkg::ST_Y_WB) begin
            ybyte_nxt = ctl.rx_byte;
          end
          state_nxt = st + 6'd1;
        end
      end
      ps2mrp_pkg::K_UPDATE: begin
        xacc_nxt  = xacc_r + dx;
        yacc_nxt  = yacc_r + dy;
        ovf_nxt   = status_r[ps2mrp_pkg::STAT_X_OVF] | status_r[ps2mrp_pkg::STAT_Y_OVF];
        mark_nxt  = now_us;
        state_nxt = ps2mrp_pkg::ST_POLLWAIT;
      end
      ps2mrp_pkg::K_POLLWAIT: begin
        if (poll_done) begin
          state_nxt = ps2mrp_pkg::ST_POLL_WR;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit the step when the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ps2mrp_pkg::ST_IDLE;
      mark_r   <= '0;
      status_r <= '0;
      xbyte_r  <= '0;
      ybyte_r  <= '0;
      xacc_r   <= '0;
      yacc_r   <= '0;
      ovf_r    <= 1'b0;
      wreq_r   <= 1'b0;
      rreq_r   <= 1'b0;
    end else if (advance) begin
      state_r  <= state_nxt;
      mark_r   <= mark_nxt;
      status_r <= status_nxt;
      xbyte_r  <= xbyte_nxt;
      ybyte_r  <= ybyte_nxt;
      xacc_r   <= xacc_nxt;
      yacc_r   <= yacc_nxt;
      ovf_r    <= ovf_nxt;
      wreq_r   <= wreq_nxt;
      rreq_r   <= rreq_nxt;
    end
  end

  // Command byte carries no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      wdata_r <= wdata_nxt;
    end
  end

  assign res.write_request = wreq_r;
  assign res.write_data    = wdata_r;
  assign res.read_request  = rreq_r;
  assign res.overflow_flag = ovf_r;
  assign res.status_byte   = status_r;
  assign pos_x             = xacc_r;
  assign pos_y             = yacc_r;

endmodule

`default_nettype wire

// ===== sv/ps2_mouse_remote_poll_sequencer.sv =====
// Top level of the PS/2 mouse remote-mode poll sequencer.
//
//  Channel | Ports                      | Direction | Payload
//  --------+----------------------------+-----------+------------------------------------
//  in      | in_tvalid/tready/tdata     | slave     | one update tick
//  out     | out_tvalid/tready/tdata    | master    | link command and position per tick
//  cfg     | cfg_valid/ready/index/data | slave     | register writes, always ready
//
// Each update request yields exactly one result, offered once it has passed the input register
// and then the sequencer step into the result register.
// A request can be accepted every cycle while results are taken; the step is one 32-bit
// subtract-and-compare plus the accumulator adds.
// Reset is synchronous (rst_n low): idle state, cleared bytes and accumulators, config defaults.
// A stalled result holds the input register; the input side stalls only when both are full.
`default_nettype none

module ps2_mouse_remote_poll_sequencer #(
  parameter int POS_WIDTH  = ps2mrp_pkg::POS_WIDTH_DEF,
  parameter int TIME_WIDTH = ps2mrp_pkg::TIME_WIDTH_DEF,
  localparam int IN_BITS   = 10 + TIME_WIDTH,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 19 + 2 * POS_WIDTH,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst_n,
  // in_tdata, lowest bit up: start_req, link_busy, rx_byte[7:0],
  // now_us[TIME_WIDTH-1:0], zero pad
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire  [IN_W-1:0]  in_tdata,
  // out_tdata, lowest bit up: write_request, write_data[7:0], read_request,
  // pos_x[POS_WIDTH-1:0], pos_y[POS_WIDTH-1:0], overflow_flag,
  // status_byte[7:0], zero pad
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [1:0]       cfg_index,
  input  wire  [31:0]      cfg_data
);

  ps2mrp_pkg::cfg_t      cfg_r;
  logic                  s1_valid_r;
  ps2mrp_pkg::step_ctl_t s1_ctl_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic                  out_valid_r;
  logic                  advance;

  ps2mrp_pkg::seq_res_t         res;
  logic signed [POS_WIDTH-1:0]  pos_x;
  logic signed [POS_WIDTH-1:0]  pos_y;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_us     <= ps2mrp_pkg::POLL_RST;
      cfg_r.sample_rate <= ps2mrp_pkg::RATE_RST;
      cfg_r.resolution  <= ps2mrp_pkg::RES_RST;
      cfg_r.settle_us   <= ps2mrp_pkg::SETTLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ps2mrp_pkg::CFG_POLL_IDX:   cfg_r.poll_us     <= cfg_data;
        ps2mrp_pkg::CFG_RATE_IDX:   cfg_r.sample_rate <= cfg_data[7:0];
        ps2mrp_pkg::CFG_RES_IDX:    cfg_r.resolution  <= cfg_data[1:0];
        ps2mrp_pkg::CFG_SETTLE_IDX: cfg_r.settle_us   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Move the held request into the result register when that slot frees up
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Track occupancy of the input and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_ctl_r.start_req <= in_tdata[0];
      s1_ctl_r.link_busy <= in_tdata[1];
      s1_ctl_r.rx_byte   <= in_tdata[9:2];
      s1_now_r           <= in_tdata[IN_BITS-1:10];
    end
  end

  ps2mrp_seq #(
    .POS_WIDTH  (POS_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ctl     (s1_ctl_r),
    .now_us  (s1_now_r),
    .cfg     (cfg_r),
    .res     (res),
    .pos_x   (pos_x),
    .pos_y   (pos_y)
  );

  // Pack the result
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({res.status_byte, res.overflow_flag, pos_y, pos_x,
                              res.read_request, res.write_data, res.write_request});

  // A tick never asks the link to send and receive at once
  a_no_dual_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res.write_request && res.read_request))
    else $error("write and read requested in the same tick");

  // Without a send request the command byte reads zero
  a_wdata_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res.write_request) |-> (res.write_data == 8'h00))
    else $error("command byte nonzero without a send request");

  // A request that steps always yields a result next cycle
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("stepped request did not reach the result register");

endmodule

`default_nettype wire

// ===== tb/ps2_mouse_remote_poll_sequencer_tb.sv =====
// Self-checking testbench for the PS/2 mouse remote-mode poll sequencer.
module ps2_mouse_remote_poll_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = 48;
  localparam int OUT_W = 56;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One predicted or observed result of an update request
  typedef struct packed {
    logic        wreq;
    logic [7:0]  wdata;
    logic        rreq;
    logic [15:0] px;
    logic [15:0] py;
    logic        ovf;
    logic [7:0]  stat;
  } tick_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  // Test control
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_results = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  logic [31:0] now_clock = 32'd0;

  // Predicted sequencer state and settings
  logic [31:0] cfg_poll = ps2mrp_pkg::POLL_RST;
  logic [7:0]  cfg_rate = ps2mrp_pkg::RATE_RST;
  logic [1:0]  cfg_res = ps2mrp_pkg::RES_RST;
  logic [15:0] cfg_settle = ps2mrp_pkg::SETTLE_RST;
  logic [5:0]  seq_state = ps2mrp_pkg::ST_IDLE;
  logic [31:0] mark_us = '0;
  logic [7:0]  stat_reg = '0;
  logic [7:0]  x_byte = '0;
  logic [7:0]  y_byte = '0;
  logic [15:0] x_pos = '0;
  logic [15:0] y_pos = '0;
  logic        ovf_reg = 1'b0;
  logic        x_wrapped = 1'b0;
  logic        y_wrapped = 1'b0;
  int unsigned polls_done = 0;
  int unsigned restarts = 0;
  tick_out_t   predicted_outputs[$];

  ps2_mouse_remote_poll_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive result ready: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (hold_results) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Advance the sequencer prediction by one update request
  task automatic step_poll_sequencer(input logic start, input logic busy,
                                     input logic [7:0] rx, input logic [31:0] now);
    tick_out_t   r;
    logic [5:0]  s;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [31:0] since_mark;
    r = '0;
    if (start) begin
      seq_state = ps2mrp_pkg::ST_START;
      restarts++;
    end
    s = seq_state;
    since_mark = now - mark_us;
    case (s)
      ps2mrp_pkg::ST_START: begin
        mark_us = now;
        seq_state = s + 6'd1;
      end
      ps2mrp_pkg::ST_SETTLE_INIT, ps2mrp_pkg::ST_SETTLE_SETUP: begin
        if (since_mark >= {16'b0, cfg_settle}) seq_state = s + 6'd1;
      end
      ps2mrp_pkg::ST_RST_WR, ps2mrp_pkg::ST_REM_WR, ps2mrp_pkg::ST_SR_WR,
      ps2mrp_pkg::ST_RES_WR, ps2mrp_pkg::ST_POLL_WR, ps2mrp_pkg::ST_SRARG_WR,
      ps2mrp_pkg::ST_RESARG_WR: begin
        r.wreq = 1'b1;
        case (s)
          ps2mrp_pkg::ST_RST_WR:   r.wdata = ps2mrp_pkg::CMD_RESET;
          ps2mrp_pkg::ST_REM_WR:   r.wdata = ps2mrp_pkg::CMD_REMOTE;
          ps2mrp_pkg::ST_SR_WR:    r.wdata = ps2mrp_pkg::CMD_SAMPLE;
          ps2mrp_pkg::ST_RES_WR:   r.wdata = ps2mrp_pkg::CMD_RESOLUTION;
          ps2mrp_pkg::ST_POLL_WR:  r.wdata = ps2mrp_pkg::CMD_READ_DATA;
          ps2mrp_pkg::ST_SRARG_WR: r.wdata = cfg_rate;
          default:                 r.wdata = {6'b0, cfg_res};
        endcase
        seq_state = s + 6'd1;
      end
      ps2mrp_pkg::ST_RSTACK_RD, ps2mrp_pkg::ST_BLANK1_RD, ps2mrp_pkg::ST_BLANK2_RD,
      ps2mrp_pkg::ST_REMACK_RD, ps2mrp_pkg::ST_SRACK_RD, ps2mrp_pkg::ST_SRARGACK_RD,
      ps2mrp_pkg::ST_RESACK_RD, ps2mrp_pkg::ST_RESARGACK_RD, ps2mrp_pkg::ST_POLLACK_RD,
      ps2mrp_pkg::ST_STAT_RD, ps2mrp_pkg::ST_X_RD, ps2mrp_pkg::ST_Y_RD: begin
        r.rreq = 1'b1;
        seq_state = s + 6'd1;
      end
      ps2mrp_pkg::ST_RST_WB, ps2mrp_pkg::ST_RSTACK_WB, ps2mrp_pkg::ST_BLANK1_WB,
      ps2mrp_pkg::ST_BLANK2_WB, ps2mrp_pkg::ST_REM_WB, ps2mrp_pkg::ST_REMACK_WB,
      ps2mrp_pkg::ST_SR_WB, ps2mrp_pkg::ST_SRACK_WB, ps2mrp_pkg::ST_SRARG_WB,
      ps2mrp_pkg::ST_SRARGACK_WB, ps2mrp_pkg::ST_RES_WB, ps2mrp_pkg::ST_RESACK_WB,
      ps2mrp_pkg::ST_RESARG_WB, ps2mrp_pkg::ST_SETUP_END_WB, ps2mrp_pkg::ST_POLL_WB,
      ps2mrp_pkg::ST_POLLACK_WB, ps2mrp_pkg::ST_STAT_WB, ps2mrp_pkg::ST_X_WB,
      ps2mrp_pkg::ST_Y_WB: begin
        // hold until the link goes idle, capturing on the way out
        if (!busy) begin
          case (s)
            ps2mrp_pkg::ST_SETUP_END_WB: mark_us = now;
            ps2mrp_pkg::ST_STAT_WB:      stat_reg = rx;
            ps2mrp_pkg::ST_X_WB:         x_byte = rx;
            ps2mrp_pkg::ST_Y_WB:         y_byte = rx;
            default: ;
          endcase
          seq_state = s + 6'd1;
        end
      end
      ps2mrp_pkg::ST_UPDATE: begin
        dx = {{8{stat_reg[ps2mrp_pkg::STAT_X_SIGN]}}, x_byte};
        dy = {{8{stat_reg[ps2mrp_pkg::STAT_Y_SIGN]}}, y_byte};
        nx = x_pos + dx;
        ny = y_pos + dy;
        // note signed wrap of the accumulators
        if (x_pos[15] == dx[15] && nx[15] != x_pos[15]) x_wrapped = 1'b1;
        if (y_pos[15] == dy[15] && ny[15] != y_pos[15]) y_wrapped = 1'b1;
        x_pos = nx;
        y_pos = ny;
        ovf_reg = stat_reg[ps2mrp_pkg::STAT_X_OVF] | stat_reg[ps2mrp_pkg::STAT_Y_OVF];
        mark_us = now;
        seq_state = ps2mrp_pkg::ST_POLLWAIT;
        polls_done++;
      end
      ps2mrp_pkg::ST_POLLWAIT: begin
        if (since_mark >= cfg_poll) seq_state = ps2mrp_pkg::ST_POLL_WR;
      end
      default: ;
    endcase
    r.px = x_pos;
    r.py = y_pos;
    r.ovf = ovf_reg;
    r.stat = stat_reg;
    predicted_outputs.push_back(r);
  endtask

  // Offer one update request, with an optional gap, and predict it on acceptance
  task automatic send_tick(input logic start, input logic busy,
                           input logic [7:0] rx, input logic [31:0] now);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, now, rx, busy, start};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    step_poll_sequencer(start, busy, rx, now);
    requests_sent++;
  endtask

  // Next time stamp: mostly small steps, or a jump at random or near a wait boundary
  function automatic logic [31:0] next_now(input int jump_pct);
    logic [31:0] span;
    span = (seq_state == ps2mrp_pkg::ST_POLLWAIT) ? cfg_poll : {16'b0, cfg_settle};
    if ($urandom_range(99) < jump_pct) begin
      case ($urandom_range(3))
        0:       now_clock = $urandom;
        1:       now_clock = mark_us - 32'd1;
        2:       now_clock = mark_us + span;
        default: now_clock = mark_us + span - 32'd1;
      endcase
    end else begin
      now_clock = now_clock + $urandom_range(0, 40);
    end
    return now_clock;
  endfunction

  // Start a sequence, then run it with random link bytes, busy and rare restarts
  task automatic send_random_ticks(input int count, input int start_pct, input int jump_pct);
    logic start;
    for (int i = 0; i < count; i++) begin
      start = (i == 0) || ($urandom_range(99) < start_pct);
      send_tick(start, $urandom_range(99) < 30, 8'($urandom_range(255)), next_now(jump_pct));
    end
  endtask

  // Drop valid and wait for every predicted result, then let the pipeline empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      ps2mrp_pkg::CFG_POLL_IDX: cfg_poll = value;
      ps2mrp_pkg::CFG_RATE_IDX: cfg_rate = value[7:0];
      ps2mrp_pkg::CFG_RES_IDX:  cfg_res = value[1:0];
      default:                  cfg_settle = value[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] poll, input logic [7:0] rate,
                                input logic [1:0] res, input logic [15:0] settle);
    drain_results();
    write_register(ps2mrp_pkg::CFG_POLL_IDX, poll);
    write_register(ps2mrp_pkg::CFG_RATE_IDX, {24'b0, rate});
    write_register(ps2mrp_pkg::CFG_RES_IDX, {30'b0, res});
    write_register(ps2mrp_pkg::CFG_SETTLE_IDX, {16'b0, settle});
  endtask

  // Idle outputs, settle wait across the time wrap, busy hold, restart mid-setup
  task automatic test_startup_directed();
    send_tick(1'b0, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0, 8'h00, 32'h0000_0000);
    send_tick(1'b1, 1'b0, 8'hAA, 32'hFFFF_FFC0);
    send_tick(1'b0, 1'b0, 8'h55, 32'h0000_0023);
    send_tick(1'b0, 1'b0, 8'h55, 32'h0000_0024);
    send_tick(1'b0, 1'b1, 8'h00, 32'h0000_0030);
    send_tick(1'b0, 1'b1, 8'hFA, 32'h0000_0031);
    send_tick(1'b0, 1'b0, 8'hFA, 32'h0000_0032);
    send_tick(1'b0, 1'b0, 8'hFA, 32'h0000_0033);
    send_tick(1'b0, 1'b0, 8'hFA, 32'h0000_0034);
    send_tick(1'b0, 1'b0, 8'hAA, 32'h0000_0035);
    send_tick(1'b1, 1'b1, 8'h00, 32'h8000_0000);
    send_tick(1'b0, 1'b0, 8'h00, mark_us + {16'b0, cfg_settle} - 32'd1);
    send_tick(1'b0, 1'b0, 8'h00, mark_us + {16'b0, cfg_settle});
    send_tick(1'b0, 1'b1, 8'hFF, 32'h8000_0100);
    send_tick(1'b0, 1'b0, 8'hFA, 32'h8000_0101);
    now_clock = 32'h8000_0101;
  endtask

  // Run the full setup and several polls on the reset settings
  task automatic test_reset_settings();
    send_random_ticks(80, 1, 15);
  endtask

  // Zero intervals: every timed wait ends on its first tick
  task automatic test_low_extremes();
    apply_settings(32'd0, 8'd0, 2'd0, 16'd0);
    send_random_ticks(150, 2, 10);
  endtask

  // Longest intervals: waits end only on large time steps
  task automatic test_high_extremes();
    apply_settings(32'hFFFF_FFFF, 8'hFF, 2'd3, 16'hFFFF);
    send_random_ticks(150, 1, 25);
  endtask

  // Hold results off while requests keep coming, then pause until all have come
  task automatic test_output_backpressure();
    apply_settings(32'd20, 8'd60, 2'd1, 16'd10);
    fork
      begin
        hold_results <= 1'b1;
        repeat (300) @(posedge clk);
        hold_results <= 1'b0;
      end
    join_none
    send_random_ticks(40, 0, 10);
    drain_results();
  endtask

  task automatic test_mixed_settings();
    repeat (2) begin
      apply_settings($urandom_range(0, 300), 8'($urandom_range(255)),
                     2'($urandom_range(3)), 16'($urandom_range(0, 60)));
      send_random_ticks(125, 2, 10);
    end
  endtask

  // Drive steady negative motion until both accumulators wrap or 300 polls have run
  task automatic test_position_wrap();
    int unsigned first_poll;
    logic [1:0]  ovf_bits;
    logic [3:0]  low_bits;
    logic [7:0]  rx;
    apply_settings(32'd0, 8'd100, 2'd2, 16'd0);
    x_wrapped = 1'b0;
    y_wrapped = 1'b0;
    first_poll = polls_done;
    send_tick(1'b1, 1'b0, 8'h00, next_now(0));
    while (!(x_wrapped && y_wrapped) && polls_done - first_poll < 300) begin
      ovf_bits = 2'($urandom_range(3));
      low_bits = 4'($urandom_range(15));
      case (seq_state)
        ps2mrp_pkg::ST_STAT_WB:                   rx = {ovf_bits, 2'b11, low_bits};
        ps2mrp_pkg::ST_X_WB, ps2mrp_pkg::ST_Y_WB: rx = 8'($urandom_range(1));
        default:                                  rx = 8'($urandom_range(255));
      endcase
      send_tick(1'b0, $urandom_range(99) < 10, rx, next_now(5));
    end
  endtask

  // Check each accepted result against the oldest prediction
  always @(negedge clk) begin
    tick_out_t want;
    tick_out_t seen;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      seen.wreq = out_tdata[0];
      seen.wdata = out_tdata[8:1];
      seen.rreq = out_tdata[9];
      seen.px = out_tdata[25:10];
      seen.py = out_tdata[41:26];
      seen.ovf = out_tdata[42];
      seen.stat = out_tdata[50:43];
      if (predicted_outputs.size() == 0) begin
        failures++;
        if (failures <= 10) $display("ERROR: result with no request pending: %h", out_tdata);
      end else begin
        want = predicted_outputs.pop_front();
        results_checked++;
        if (seen.wreq !== want.wreq || seen.wdata !== want.wdata ||
            seen.rreq !== want.rreq || seen.px !== want.px || seen.py !== want.py ||
            seen.ovf !== want.ovf || seen.stat !== want.stat) begin
          failures++;
          if (failures <= 10) begin
            $display("ERROR: result %0d wr %b/%h rd %b x %h y %h ovf %b st %h",
                     results_checked, want.wreq, want.wdata, want.rreq, want.px, want.py,
                     want.ovf, want.stat);
            $display("       got       wr %b/%h rd %b x %h y %h ovf %b st %h",
                     seen.wreq, seen.wdata, seen.rreq, seen.px, seen.py, seen.ovf,
                     seen.stat);
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 66;
    test_startup_directed();
    test_reset_settings();
    test_low_extremes();

    send_idle_pct = 66;
    recv_idle_pct = 36;
    test_high_extremes();
    test_output_backpressure();
    test_mixed_settings();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_position_wrap();
    drain_results();

    $display("Checked %0d results for %0d update requests: %0d mouse polls, %0d restarts.",
             results_checked, requests_sent, polls_done, restarts);
    $display("Settings ran from all-zero to all-ones; stalls, idle gaps and full-rate streams.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ps2mrp_pkg.sv
sv/ps2mrp_seq.sv
sv/ps2_mouse_remote_poll_sequencer.sv
tb/ps2_mouse_remote_poll_sequencer_tb.sv
